/* rtl/core/scpq_pkg.sv */
package scpq_pkg;

	localparam int DEPTH       = 64;
	localparam int ADDR_W      = $clog2(DEPTH);
	localparam int CNT_W       = $clog2(DEPTH + 1);
	localparam int ID_W        = 32;
	localparam int DIST_W      = 32;
	localparam int ACT_W       = 3;
	localparam int COUNT_OUT_W = 7;
	localparam int IN_DATA_W   = 72;
	localparam int OUT_DATA_W  = 80;

	typedef enum logic [ACT_W-1:0] {
		ACT_PUSH  = 3'd0,
		ACT_POP   = 3'd1,
		ACT_PEEK  = 3'd2,
		ACT_FIND  = 3'd3,
		ACT_CLEAR = 3'd4
	} action_t;

	typedef struct packed {
		logic [ID_W-1:0]   id;
		logic [DIST_W-1:0] distance;
		logic              net;
	} entry_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_DECODE,
		ST_PUSH_RD,
		ST_PUSH_CHK,
		ST_POP_EMIT,
		ST_POP_RD,
		ST_POP_WR,
		ST_PEEK_EMIT,
		ST_FIND_RD,
		ST_FIND_CHK,
		ST_DONE
	} state_t;

	typedef enum logic [2:0] {
		IDX_HOLD,
		IDX_LOAD_CNT,
		IDX_LOAD_ZERO,
		IDX_LOAD_ONE,
		IDX_INC,
		IDX_DEC
	} idx_op_t;

	typedef enum logic [1:0] {
		RD_ZERO,
		RD_IDX,
		RD_IDX_M1
	} rd_sel_t;

	typedef enum logic [1:0] {
		WR_NEW_AT_IDX,
		WR_ENTRY_AT_IDX,
		WR_ENTRY_AT_IDX_M1
	} wr_sel_t;

	typedef enum logic [1:0] {
		CNT_HOLD,
		CNT_INC,
		CNT_DEC,
		CNT_CLR
	} cnt_op_t;

	typedef enum logic [1:0] {
		RES_HOLD,
		RES_CLR,
		RES_ENTRY,
		RES_OVF
	} res_op_t;

	typedef struct packed {
		logic    capture;
		idx_op_t idx_op;
		logic    mem_re;
		rd_sel_t rd_sel;
		logic    mem_we;
		wr_sel_t wr_sel;
		cnt_op_t cnt_op;
		res_op_t res_op;
		logic    out_load;
	} cmd_t;

	typedef struct packed {
		action_t act;
		logic    cnt_zero;
		logic    cnt_full;
		logic    idx_zero;
		logic    idx_end;
		logic    new_before;
		logic    id_match;
		logic    out_free;
	} stat_t;

endpackage

/* rtl/core/scpq_ctrl.sv */
module scpq_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            s_tvalid,
	output logic            s_tready,
	input  scpq_pkg::stat_t st,
	output scpq_pkg::cmd_t  cmd
);

	scpq_pkg::state_t state_q;
	scpq_pkg::state_t state_d;

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= scpq_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	assign s_tready = (state_q == scpq_pkg::ST_IDLE);

	// Next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			scpq_pkg::ST_IDLE: begin
				if (s_tvalid) state_d = scpq_pkg::ST_DECODE;
			end
			scpq_pkg::ST_DECODE: begin
				unique case (st.act)
					scpq_pkg::ACT_PUSH: begin
						state_d = st.cnt_full ? scpq_pkg::ST_DONE : scpq_pkg::ST_PUSH_RD;
					end
					scpq_pkg::ACT_POP: begin
						state_d = st.cnt_zero ? scpq_pkg::ST_DONE : scpq_pkg::ST_POP_EMIT;
					end
					scpq_pkg::ACT_PEEK: begin
						state_d = st.cnt_zero ? scpq_pkg::ST_DONE : scpq_pkg::ST_PEEK_EMIT;
					end
					scpq_pkg::ACT_FIND: begin
						state_d = scpq_pkg::ST_FIND_RD;
					end
					default: begin
						state_d = scpq_pkg::ST_DONE;
					end
				endcase
			end
			scpq_pkg::ST_PUSH_RD: begin
				state_d = st.idx_zero ? scpq_pkg::ST_DONE : scpq_pkg::ST_PUSH_CHK;
			end
			scpq_pkg::ST_PUSH_CHK: begin
				state_d = st.new_before ? scpq_pkg::ST_PUSH_RD : scpq_pkg::ST_DONE;
			end
			scpq_pkg::ST_POP_EMIT: begin
				state_d = scpq_pkg::ST_POP_RD;
			end
			scpq_pkg::ST_POP_RD: begin
				state_d = st.idx_end ? scpq_pkg::ST_DONE : scpq_pkg::ST_POP_WR;
			end
			scpq_pkg::ST_POP_WR: begin
				state_d = scpq_pkg::ST_POP_RD;
			end
			scpq_pkg::ST_PEEK_EMIT: begin
				state_d = scpq_pkg::ST_DONE;
			end
			scpq_pkg::ST_FIND_RD: begin
				state_d = st.idx_end ? scpq_pkg::ST_DONE : scpq_pkg::ST_FIND_CHK;
			end
			scpq_pkg::ST_FIND_CHK: begin
				state_d = st.id_match ? scpq_pkg::ST_DONE : scpq_pkg::ST_FIND_RD;
			end
			scpq_pkg::ST_DONE: begin
				if (st.out_free) state_d = scpq_pkg::ST_IDLE;
			end
			default: begin
				state_d = scpq_pkg::ST_IDLE;
			end
		endcase
	end

	// Datapath commands
	always_comb begin
		cmd.capture  = 1'b0;
		cmd.idx_op   = scpq_pkg::IDX_HOLD;
		cmd.mem_re   = 1'b0;
		cmd.rd_sel   = scpq_pkg::RD_IDX;
		cmd.mem_we   = 1'b0;
		cmd.wr_sel   = scpq_pkg::WR_NEW_AT_IDX;
		cmd.cnt_op   = scpq_pkg::CNT_HOLD;
		cmd.res_op   = scpq_pkg::RES_HOLD;
		cmd.out_load = 1'b0;
		unique case (state_q)
			scpq_pkg::ST_IDLE: begin
				cmd.capture = s_tvalid;
			end
			scpq_pkg::ST_DECODE: begin
				cmd.res_op = scpq_pkg::RES_CLR;
				unique case (st.act) inside
					scpq_pkg::ACT_PUSH: begin
						if (st.cnt_full) cmd.res_op = scpq_pkg::RES_OVF;
						cmd.idx_op = scpq_pkg::IDX_LOAD_CNT;
					end
					scpq_pkg::ACT_POP, scpq_pkg::ACT_PEEK: begin
						cmd.mem_re = !st.cnt_zero;
						cmd.rd_sel = scpq_pkg::RD_ZERO;
					end
					scpq_pkg::ACT_FIND: begin
						cmd.idx_op = scpq_pkg::IDX_LOAD_ZERO;
					end
					scpq_pkg::ACT_CLEAR: begin
						cmd.cnt_op = scpq_pkg::CNT_CLR;
					end
					default: begin
						cmd.res_op = scpq_pkg::RES_CLR;
					end
				endcase
			end
			scpq_pkg::ST_PUSH_RD: begin
				if (st.idx_zero) begin
					cmd.mem_we = 1'b1;
					cmd.wr_sel = scpq_pkg::WR_NEW_AT_IDX;
					cmd.cnt_op = scpq_pkg::CNT_INC;
				end else begin
					cmd.mem_re = 1'b1;
					cmd.rd_sel = scpq_pkg::RD_IDX_M1;
				end
			end
			scpq_pkg::ST_PUSH_CHK: begin
				cmd.mem_we = 1'b1;
				if (st.new_before) begin
					cmd.wr_sel = scpq_pkg::WR_ENTRY_AT_IDX;
					cmd.idx_op = scpq_pkg::IDX_DEC;
				end else begin
					cmd.wr_sel = scpq_pkg::WR_NEW_AT_IDX;
					cmd.cnt_op = scpq_pkg::CNT_INC;
				end
			end
			scpq_pkg::ST_POP_EMIT: begin
				cmd.res_op = scpq_pkg::RES_ENTRY;
				cmd.idx_op = scpq_pkg::IDX_LOAD_ONE;
			end
			scpq_pkg::ST_POP_RD: begin
				if (st.idx_end) begin
					cmd.cnt_op = scpq_pkg::CNT_DEC;
				end else begin
					cmd.mem_re = 1'b1;
					cmd.rd_sel = scpq_pkg::RD_IDX;
				end
			end
			scpq_pkg::ST_POP_WR: begin
				cmd.mem_we = 1'b1;
				cmd.wr_sel = scpq_pkg::WR_ENTRY_AT_IDX_M1;
				cmd.idx_op = scpq_pkg::IDX_INC;
			end
			scpq_pkg::ST_PEEK_EMIT: begin
				cmd.res_op = scpq_pkg::RES_ENTRY;
			end
			scpq_pkg::ST_FIND_RD: begin
				if (!st.idx_end) begin
					cmd.mem_re = 1'b1;
					cmd.rd_sel = scpq_pkg::RD_IDX;
				end
			end
			scpq_pkg::ST_FIND_CHK: begin
				if (st.id_match) begin
					cmd.res_op = scpq_pkg::RES_ENTRY;
				end else begin
					cmd.idx_op = scpq_pkg::IDX_INC;
				end
			end
			scpq_pkg::ST_DONE: begin
				cmd.out_load = st.out_free;
			end
			default: begin
				cmd.capture = 1'b0;
			end
		endcase
	end

endmodule

/* rtl/core/scpq_dp.sv */
module scpq_dp (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic [scpq_pkg::IN_DATA_W-1:0]      s_tdata,
	input  logic [scpq_pkg::ACT_W-1:0]          s_tuser,
	output logic                                m_tvalid,
	input  logic                                m_tready,
	output logic [scpq_pkg::OUT_DATA_W-1:0]     m_tdata,
	output logic                                m_tuser,
	input  scpq_pkg::cmd_t                      cmd,
	output scpq_pkg::stat_t                     st
);

	// Entry store, one write and one registered read per cycle
	scpq_pkg::entry_t mem [scpq_pkg::DEPTH];

	scpq_pkg::action_t                  act_q;
	scpq_pkg::entry_t                   item_q;
	scpq_pkg::entry_t                   rdata_q;
	logic [scpq_pkg::CNT_W-1:0]         idx_q;
	logic [scpq_pkg::CNT_W-1:0]         idx_m1;
	logic [scpq_pkg::CNT_W-1:0]         count_q;
	logic                               res_found_q;
	scpq_pkg::entry_t                   res_entry_q;
	logic                               res_ovf_q;
	logic                               out_valid_q;
	logic                               out_found_q;
	scpq_pkg::entry_t                   out_entry_q;
	logic [scpq_pkg::COUNT_OUT_W-1:0]   out_count_q;
	logic                               out_ovf_q;
	logic [scpq_pkg::ADDR_W-1:0]        raddr;
	logic [scpq_pkg::ADDR_W-1:0]        waddr;
	scpq_pkg::entry_t                   wdata;

	assign idx_m1 = idx_q - scpq_pkg::CNT_W'(1);

	// Capture the incoming transaction
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			act_q           <= scpq_pkg::action_t'(s_tuser);
			item_q.id       <= s_tdata[scpq_pkg::ID_W-1:0];
			item_q.distance <= s_tdata[scpq_pkg::ID_W +: scpq_pkg::DIST_W];
			item_q.net      <= s_tdata[scpq_pkg::ID_W + scpq_pkg::DIST_W];
		end
	end

	// Select memory addresses and write data
	always_comb begin
		case (cmd.rd_sel)
			scpq_pkg::RD_ZERO:   raddr = '0;
			scpq_pkg::RD_IDX_M1: raddr = idx_m1[scpq_pkg::ADDR_W-1:0];
			default:             raddr = idx_q[scpq_pkg::ADDR_W-1:0];
		endcase
		case (cmd.wr_sel)
			scpq_pkg::WR_ENTRY_AT_IDX: begin
				waddr = idx_q[scpq_pkg::ADDR_W-1:0];
				wdata = rdata_q;
			end
			scpq_pkg::WR_ENTRY_AT_IDX_M1: begin
				waddr = idx_m1[scpq_pkg::ADDR_W-1:0];
				wdata = rdata_q;
			end
			default: begin
				waddr = idx_q[scpq_pkg::ADDR_W-1:0];
				wdata = item_q;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (cmd.mem_we) mem[waddr] <= wdata;
	end

	always_ff @(posedge clk) begin
		if (cmd.mem_re) rdata_q <= mem[raddr];
	end

	// Walk index and entry count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q   <= '0;
			count_q <= '0;
		end else begin
			case (cmd.idx_op)
				scpq_pkg::IDX_LOAD_CNT:  idx_q <= count_q;
				scpq_pkg::IDX_LOAD_ZERO: idx_q <= '0;
				scpq_pkg::IDX_LOAD_ONE:  idx_q <= scpq_pkg::CNT_W'(1);
				scpq_pkg::IDX_INC:       idx_q <= idx_q + scpq_pkg::CNT_W'(1);
				scpq_pkg::IDX_DEC:       idx_q <= idx_m1;
				default:                 idx_q <= idx_q;
			endcase
			case (cmd.cnt_op)
				scpq_pkg::CNT_INC: count_q <= count_q + scpq_pkg::CNT_W'(1);
				scpq_pkg::CNT_DEC: count_q <= count_q - scpq_pkg::CNT_W'(1);
				scpq_pkg::CNT_CLR: count_q <= '0;
				default:           count_q <= count_q;
			endcase
		end
	end

	// Build the result of the current transaction
	always_ff @(posedge clk) begin
		case (cmd.res_op)
			scpq_pkg::RES_CLR: begin
				res_found_q <= 1'b0;
				res_entry_q <= '0;
				res_ovf_q   <= 1'b0;
			end
			scpq_pkg::RES_ENTRY: begin
				res_found_q <= 1'b1;
				res_entry_q <= rdata_q;
				res_ovf_q   <= 1'b0;
			end
			scpq_pkg::RES_OVF: begin
				res_found_q <= 1'b0;
				res_entry_q <= '0;
				res_ovf_q   <= 1'b1;
			end
			default: begin
				res_found_q <= res_found_q;
			end
		endcase
	end

	// Output register, held until the sink takes it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.out_load) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			out_found_q <= res_found_q;
			out_entry_q <= res_entry_q;
			out_count_q <= scpq_pkg::COUNT_OUT_W'(count_q);
			out_ovf_q   <= res_ovf_q;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tuser  = out_found_q;
	assign m_tdata  = {
		{(scpq_pkg::OUT_DATA_W - scpq_pkg::ID_W - scpq_pkg::DIST_W - 2
			- scpq_pkg::COUNT_OUT_W){1'b0}},
		out_ovf_q, out_count_q, out_entry_q.net, out_entry_q.distance, out_entry_q.id
	};

	// Status toward the controller
	always_comb begin
		st.act        = act_q;
		st.cnt_zero   = (count_q == '0);
		st.cnt_full   = (count_q == scpq_pkg::CNT_W'(scpq_pkg::DEPTH));
		st.idx_zero   = (idx_q == '0);
		st.idx_end    = (idx_q >= count_q);
		st.new_before = (item_q.distance < rdata_q.distance) ||
			((item_q.distance == rdata_q.distance) && item_q.net && !rdata_q.net);
		st.id_match   = (rdata_q.id == item_q.id);
		st.out_free   = !out_valid_q || m_tready;
	end

endmodule

/* rtl/core/sorted_candidate_priority_queue.sv */
// Sorted candidate queue of up to 64 entries (id, distance, network/router type), kept in rank
// order in an entry memory with one read port and one write port: smallest distance first,
// network before router on a tie, equal ranks in arrival order. Each input transaction is one
// action (push, pop, peek, find, clear) and yields exactly one result transaction. One action is
// worked at a time and each entry visited takes a read step, then a compare or move step. Clear,
// a full push, an empty pop or peek and an unknown action go straight to the result; a peek
// returns the front entry; a push walks from the back, moving each entry that ranks after it up
// one place, and a pop returns the front entry and moves every remaining entry forward one place;
// a find reads entries from the front until one matches or all have been examined. A result
// waits while the output register still holds an untaken one. The next transaction is accepted
// from the cycle after the result is parked in the output register, even if the sink has not yet
// taken it. Entry memory needs no clearing after reset.
module sorted_candidate_priority_queue (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             s_tvalid,
	output logic                             s_tready,
	// vertex_id [31:0], distance [63:32], is_network [64], zero fill [71:65]
	input  logic [scpq_pkg::IN_DATA_W-1:0]   s_tdata,
	// action [2:0]
	input  logic [scpq_pkg::ACT_W-1:0]       s_tuser,
	output logic                             m_tvalid,
	input  logic                             m_tready,
	// out_vertex_id [31:0], out_distance [63:32], out_is_network [64],
	// entry_count [71:65], overflow [72], zero fill [79:73]
	output logic [scpq_pkg::OUT_DATA_W-1:0]  m_tdata,
	// found [0]
	output logic                             m_tuser
);

	scpq_pkg::cmd_t  cmd;
	scpq_pkg::stat_t st;

	scpq_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.st       (st),
		.cmd      (cmd)
	);

	scpq_dp u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.cmd      (cmd),
		.st       (st)
	);

endmodule

/* rtl/core/scpq_checker.sv */
module scpq_checker (
	input logic                             clk,
	input logic                             arst_n,
	input logic                             s_tvalid,
	input logic                             s_tready,
	input logic                             m_tvalid,
	input logic                             m_tready,
	input logic [scpq_pkg::OUT_DATA_W-1:0]  m_tdata,
	input logic                             m_tuser
);

	// Hold a stalled result
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("stalled result changed");

	// Zero entry fields when nothing is returned
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tuser |-> m_tdata[64:0] == '0)
		else $error("entry fields not zero without a hit");

	// Drop a push only when full, and never together with a hit
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[72] |->
			!m_tuser && m_tdata[71:65] == scpq_pkg::COUNT_OUT_W'(scpq_pkg::DEPTH))
		else $error("overflow flagged below capacity");

	// Keep the reported count within capacity
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[71:65] <= scpq_pkg::COUNT_OUT_W'(scpq_pkg::DEPTH))
		else $error("entry count above capacity");

	// Accept no new transaction on the cycle after one was taken
	assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("second transaction accepted while one is in work");

endmodule

bind sorted_candidate_priority_queue scpq_checker u_scpq_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser)
);
